### rtl/core/tih_pkg.sv
package tih_pkg;

    localparam int CAPACITY  = 64;
    localparam int MAP_SLOTS = 128;
    localparam int DESC_W    = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int SLOT_W    = $clog2(MAP_SLOTS);
    localparam int PROBE_W   = $clog2(MAP_SLOTS + 1);
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MIX_SHIFT = 33;

    localparam logic [WORD_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_ID   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_STRIDE  = 2'd1;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_ALLOC,
        OP_LOOKUP,
        OP_REMOVE,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              id_zero;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DESC_W-1:0]   desc;
        logic [WORD_W-1:0]   assigned;
        logic [WORD_W-1:0]   size;
        logic [WORD_W-1:0]   value;
        logic [COUNT_W-1:0]  count;
    } t_result;

    typedef enum logic [2:0] {
        H_IDLE,
        H_P0,
        H_P1,
        H_P2,
        H_P3
    } t_hstate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_PRB_MAP,
        S_PRB_ENT,
        S_PRB_CMP,
        S_PRB_END,
        S_INS_WR,
        S_SH_MAP,
        S_SH_ENT,
        S_SH_KEY,
        S_SH_END,
        S_DONE
    } t_state;

endpackage

### rtl/core/tih_fifo.sv
module tih_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= !r_wp;
            end
            if (w_do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_do_push} - {1'b0, w_do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/core/tih_front.sv
module tih_front import tih_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [WORD_W-1:0] i_transfer_id,
    input  logic [WORD_W-1:0] i_total_size,
    input  logic [WORD_W-1:0] i_user_value,
    output t_item             o_item,
    output logic              o_item_valid,
    input  logic              i_item_take
);

    t_item w_item;
    logic  w_empty;

    always_comb begin
        w_item.id      = i_transfer_id;
        w_item.size    = i_total_size;
        w_item.value   = i_user_value;
        w_item.id_zero = (i_transfer_id == '0);
        case (i_func)
            FUNC_INSERT: w_item.op = OP_INSERT;
            FUNC_ALLOC:  w_item.op = OP_ALLOC;
            FUNC_LOOKUP: w_item.op = OP_LOOKUP;
            FUNC_REMOVE: w_item.op = OP_REMOVE;
            FUNC_CLEAR:  w_item.op = OP_CLEAR;
            default:     w_item.op = OP_NOP;
        endcase
    end

    tih_fifo #(.WIDTH($bits(t_item))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_data  (w_item),
        .o_empty (w_empty),
        .i_pop   (i_item_take),
        .o_data  (o_item)
    );

    assign o_item_valid = !w_empty;

endmodule

### rtl/core/tih_hash.sv
module tih_hash import tih_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_key,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_slot
);

    t_hstate           r_state, n_state;
    logic              r_round, n_round;
    logic              r_done, n_done;
    logic [WORD_W-1:0] r_x, n_x;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_prod, n_prod;
    logic [WORD_W-1:0] w_c;
    logic [HALF_W-1:0] w_a;
    logic [HALF_W-1:0] w_b;
    logic [WORD_W-1:0] w_mul;
    logic [WORD_W-1:0] w_sum;

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] y);
        return y ^ (y >> MIX_SHIFT);
    endfunction

    assign w_c   = r_round ? MIX_C2 : MIX_C1;
    assign w_mul = WORD_W'(w_a) * WORD_W'(w_b);
    assign w_sum = r_acc + (r_prod << HALF_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_round <= n_round;
        r_x     <= n_x;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_done  = 1'b0;
        n_x     = r_x;
        n_acc   = r_acc;
        n_prod  = r_prod;
        w_a     = r_x[HALF_W-1:0];
        w_b     = w_c[HALF_W-1:0];
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_x     = mix(i_key);
                    n_round = 1'b0;
                    n_state = H_P0;
                end
            end
            H_P0: begin
                n_prod  = w_mul;
                n_state = H_P1;
            end
            H_P1: begin
                w_b     = w_c[WORD_W-1:HALF_W];
                n_acc   = r_prod;
                n_prod  = w_mul;
                n_state = H_P2;
            end
            H_P2: begin
                w_a     = r_x[WORD_W-1:HALF_W];
                n_acc   = w_sum;
                n_prod  = w_mul;
                n_state = H_P3;
            end
            H_P3: begin
                n_x = mix(w_sum);
                if (!r_round) begin
                    n_round = 1'b1;
                    n_state = H_P0;
                end else begin
                    n_done  = 1'b1;
                    n_state = H_IDLE;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_slot = r_x[SLOT_W-1:0];

endmodule

### rtl/core/tih_back.sv
module tih_back import tih_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  t_item                i_item,
    input  logic                 i_item_valid,
    output logic                 o_item_take,
    output t_result              o_res,
    output logic                 o_res_push,
    input  logic                 i_res_full
);

    localparam int ENT_W = 3 * WORD_W;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [WORD_W-1:0]    r_key, n_key;
    logic [WORD_W-1:0]    r_size, n_size;
    logic [WORD_W-1:0]    r_val, n_val;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [SLOT_W-1:0]    r_hole, n_hole;
    logic [SLOT_W-1:0]    r_next, n_next;
    logic [PROBE_W-1:0]   r_n, n_n;
    logic                 r_found, n_found;
    logic                 r_ok, n_ok;
    logic                 r_hpurp, n_hpurp;
    logic [DESC_W-1:0]    r_desc, n_desc;
    logic [DESC_W-1:0]    r_mv, n_mv;
    logic [COUNT_W-1:0]   r_tries, n_tries;
    logic [WORD_W-1:0]    r_gen, n_gen;
    logic [WORD_W-1:0]    r_stride, n_stride;
    logic [COUNT_W-1:0]   r_free_top, n_free_top;
    logic [COUNT_W-1:0]   r_live, n_live;
    logic [MAP_SLOTS-1:0] r_svalid, n_svalid;
    logic [CAPACITY-1:0]  r_lvalid, n_lvalid;
    t_result              r_res, n_res;

    logic [ENT_W-1:0]   m_entry [CAPACITY];
    logic [DESC_W-1:0]  m_map [MAP_SLOTS];
    logic [COUNT_W-1:0] m_link [CAPACITY];
    logic [ENT_W-1:0]   r_ent_q;
    logic [DESC_W-1:0]  r_map_q;
    logic [COUNT_W-1:0] r_link_q;

    logic               w_ent_we;
    logic [DESC_W-1:0]  w_ent_raddr;
    logic               w_map_we;
    logic [SLOT_W-1:0]  w_map_waddr;
    logic [DESC_W-1:0]  w_map_wdata;
    logic [SLOT_W-1:0]  w_map_raddr;
    logic               w_link_we;
    logic [DESC_W-1:0]  w_link_waddr;
    logic [COUNT_W-1:0] w_link_wdata;
    logic [DESC_W-1:0]  w_top_desc;

    logic               w_hstart;
    logic [WORD_W-1:0]  w_hkey;
    logic               w_hdone;
    logic [SLOT_W-1:0]  w_hslot;

    logic [WORD_W-1:0]  w_cand;
    logic [WORD_W-1:0]  w_gen_next;
    logic [WORD_W-1:0]  w_cfg_val;
    logic [SLOT_W-1:0]  w_d_hole;
    logic [SLOT_W-1:0]  w_d_next;

    function automatic logic [WORD_W-1:0] step_id(input logic [WORD_W-1:0] base,
                                                  input logic [WORD_W-1:0] stride);
        logic [WORD_W-1:0] s;
        s = base + stride;
        return (s == '0) ? stride : s;
    endfunction

    tih_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (w_hkey),
        .o_done  (w_hdone),
        .o_slot  (w_hslot)
    );

    assign w_top_desc  = r_free_top[DESC_W-1:0];
    assign w_cand      = step_id(r_key, r_stride);
    assign w_gen_next  = step_id(r_key, r_stride);
    assign w_cfg_val   = (i_cfg_data == '0) ? WORD_W'(1) : i_cfg_data;
    assign w_d_hole    = r_hole - w_hslot;
    assign w_d_next    = r_next - w_hslot;
    assign w_ent_raddr = (r_state == S_PRB_ENT || r_state == S_SH_ENT) ? r_map_q : r_desc;
    assign w_map_raddr = (r_state == S_SH_MAP) ? r_next : r_slot;

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            m_entry[w_top_desc] <= {r_key, r_size, r_val};
        end
        r_ent_q <= m_entry[w_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            m_map[w_map_waddr] <= w_map_wdata;
        end
        r_map_q <= m_map[w_map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            m_link[w_link_waddr] <= w_link_wdata;
        end
        r_link_q <= m_link[w_top_desc];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gen      <= WORD_W'(1);
            r_stride   <= WORD_W'(1);
            r_free_top <= '0;
            r_live     <= '0;
            r_svalid   <= '0;
            r_lvalid   <= '0;
        end else begin
            r_state    <= n_state;
            r_gen      <= n_gen;
            r_stride   <= n_stride;
            r_free_top <= n_free_top;
            r_live     <= n_live;
            r_svalid   <= n_svalid;
            r_lvalid   <= n_lvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_size  <= n_size;
        r_val   <= n_val;
        r_slot  <= n_slot;
        r_hole  <= n_hole;
        r_next  <= n_next;
        r_n     <= n_n;
        r_found <= n_found;
        r_ok    <= n_ok;
        r_hpurp <= n_hpurp;
        r_desc  <= n_desc;
        r_mv    <= n_mv;
        r_tries <= n_tries;
        r_res   <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_size       = r_size;
        n_val        = r_val;
        n_slot       = r_slot;
        n_hole       = r_hole;
        n_next       = r_next;
        n_n          = r_n;
        n_found      = r_found;
        n_ok         = r_ok;
        n_hpurp      = r_hpurp;
        n_desc       = r_desc;
        n_mv         = r_mv;
        n_tries      = r_tries;
        n_gen        = r_gen;
        n_stride     = r_stride;
        n_free_top   = r_free_top;
        n_live       = r_live;
        n_svalid     = r_svalid;
        n_lvalid     = r_lvalid;
        n_res        = r_res;
        o_item_take  = 1'b0;
        o_res_push   = 1'b0;
        w_ent_we     = 1'b0;
        w_map_we     = 1'b0;
        w_map_waddr  = r_slot;
        w_map_wdata  = w_top_desc;
        w_link_we    = 1'b0;
        w_link_waddr = w_top_desc;
        w_link_wdata = COUNT_W'(CAPACITY);
        w_hstart     = 1'b0;
        w_hkey       = i_item.id;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_take = 1'b1;
                    n_op        = i_item.op;
                    n_key       = i_item.id;
                    n_size      = i_item.size;
                    n_val       = i_item.value;
                    n_hpurp     = 1'b0;
                    n_res       = '0;
                    n_state     = S_DONE;
                    case (i_item.op)
                        OP_INSERT: begin
                            if (i_item.id_zero) begin
                                n_res.status = STAT_ZERO_ID;
                            end else if (r_free_top == COUNT_W'(CAPACITY)) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                w_hstart = 1'b1;
                                n_state  = S_HASH;
                            end
                        end
                        OP_ALLOC: begin
                            if (r_free_top == COUNT_W'(CAPACITY)) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                n_key    = r_gen;
                                n_tries  = '0;
                                w_hkey   = r_gen;
                                w_hstart = 1'b1;
                                n_state  = S_HASH;
                            end
                        end
                        OP_LOOKUP, OP_REMOVE: begin
                            if (i_item.id_zero) begin
                                n_res.status = STAT_NOT_FOUND;
                            end else begin
                                w_hstart = 1'b1;
                                n_state  = S_HASH;
                            end
                        end
                        OP_CLEAR: begin
                            n_svalid   = '0;
                            n_lvalid   = '0;
                            n_free_top = '0;
                            n_live     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_HASH: begin
                if (w_hdone) begin
                    if (!r_hpurp) begin
                        n_slot  = w_hslot;
                        n_n     = '0;
                        n_state = S_PRB_MAP;
                    end else begin
                        if (w_d_hole < w_d_next) begin
                            w_map_we    = 1'b1;
                            w_map_waddr = r_hole;
                            w_map_wdata = r_mv;
                            n_hole      = r_next;
                        end
                        n_next  = r_next + SLOT_W'(1);
                        n_n     = r_n + PROBE_W'(1);
                        n_state = S_SH_MAP;
                    end
                end
            end
            S_PRB_MAP: begin
                if (r_n == PROBE_W'(MAP_SLOTS)) begin
                    n_found = 1'b0;
                    n_ok    = 1'b0;
                    n_state = S_PRB_END;
                end else if (!r_svalid[r_slot]) begin
                    n_found = 1'b0;
                    n_ok    = 1'b1;
                    n_state = S_PRB_END;
                end else begin
                    n_state = S_PRB_ENT;
                end
            end
            S_PRB_ENT: begin
                n_desc  = r_map_q;
                n_state = S_PRB_CMP;
            end
            S_PRB_CMP: begin
                if (r_ent_q[ENT_W-1:2*WORD_W] == r_key) begin
                    n_found = 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_PRB_END;
                end else begin
                    n_slot  = r_slot + SLOT_W'(1);
                    n_n     = r_n + PROBE_W'(1);
                    n_state = S_PRB_MAP;
                end
            end
            S_PRB_END: begin
                n_state = S_DONE;
                case (r_op)
                    OP_INSERT: begin
                        if (r_found) begin
                            n_res.status = STAT_DUPLICATE;
                        end else if (!r_ok) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            n_state = S_INS_WR;
                        end
                    end
                    OP_ALLOC: begin
                        if (r_found) begin
                            if (r_tries == COUNT_W'(CAPACITY - 1)) begin
                                n_res.status = STAT_EXHAUSTED;
                            end else begin
                                n_tries  = r_tries + COUNT_W'(1);
                                n_key    = w_cand;
                                w_hkey   = w_cand;
                                w_hstart = 1'b1;
                                n_state  = S_HASH;
                            end
                        end else if (!r_ok) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            n_state = S_INS_WR;
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_found) begin
                            n_res.desc     = r_desc;
                            n_res.assigned = r_key;
                            n_res.size     = r_ent_q[2*WORD_W-1:WORD_W];
                            n_res.value    = r_ent_q[WORD_W-1:0];
                        end else begin
                            n_res.status = STAT_NOT_FOUND;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            n_hole  = r_slot;
                            n_next  = r_slot + SLOT_W'(1);
                            n_n     = '0;
                            n_hpurp = 1'b1;
                            n_state = S_SH_MAP;
                        end else begin
                            n_res.status = STAT_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            S_INS_WR: begin
                w_ent_we             = 1'b1;
                w_map_we             = 1'b1;
                w_link_we            = 1'b1;
                n_svalid[r_slot]     = 1'b1;
                n_lvalid[w_top_desc] = 1'b1;
                n_free_top = r_lvalid[w_top_desc] ? r_link_q
                                                  : r_free_top + COUNT_W'(1);
                n_live         = r_live + COUNT_W'(1);
                n_res.desc     = w_top_desc;
                n_res.assigned = r_key;
                if (r_op == OP_ALLOC) begin
                    n_gen = w_gen_next;
                end
                n_state = S_DONE;
            end
            S_SH_MAP: begin
                if (r_n == PROBE_W'(MAP_SLOTS) || !r_svalid[r_next]) begin
                    n_state = S_SH_END;
                end else begin
                    n_state = S_SH_ENT;
                end
            end
            S_SH_ENT: begin
                n_mv    = r_map_q;
                n_state = S_SH_KEY;
            end
            S_SH_KEY: begin
                w_hkey   = r_ent_q[ENT_W-1:2*WORD_W];
                w_hstart = 1'b1;
                n_state  = S_HASH;
            end
            S_SH_END: begin
                n_svalid[r_hole] = 1'b0;
                w_link_we        = 1'b1;
                w_link_waddr     = r_desc;
                w_link_wdata     = r_free_top;
                n_lvalid[r_desc] = 1'b1;
                n_free_top       = COUNT_W'(r_desc);
                if (r_live != '0) begin
                    n_live = r_live - COUNT_W'(1);
                end
                n_res.desc     = r_desc;
                n_res.assigned = r_key;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INITIAL_ID: n_gen    = w_cfg_val;
                CFG_ID_STRIDE:  n_stride = w_cfg_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_res       = r_res;
        o_res.count = r_live;
    end

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= COUNT_W'(CAPACITY))
        else $error("active count above capacity");

    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_top == COUNT_W'(CAPACITY)) == (r_live == COUNT_W'(CAPACITY)))
        else $error("free list and active count disagree");

    a_map_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_svalid) == int'(r_live))
        else $error("used map slots differ from active count");

    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0 && r_stride != '0)
        else $error("generator or stride is zero");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> r_state == S_IDLE)
        else $error("result transfer did not end the operation");
`endif

endmodule

### rtl/core/transfer_id_hash_table.sv
// The block hashes an ID, then probes map slots in turn from its home slot.
// Allocate repeats hash and probe for every candidate ID already in use.
// Remove then walks the following slots with a backward shift, rehashing each key it meets.
// One operation at a time; the next one is taken only after the last result is queued.
// Reset is synchronous; map and free-list valid bits clear at once, no sweep.
module transfer_id_hash_table import tih_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [WORD_W-1:0]    i_transfer_id,
    input  logic [WORD_W-1:0]    i_total_size,
    input  logic [WORD_W-1:0]    i_user_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [STATUS_W-1:0]  o_status,
    output logic [DESC_W-1:0]    o_descriptor,
    output logic [WORD_W-1:0]    o_assigned_id,
    output logic [WORD_W-1:0]    o_size_out,
    output logic [WORD_W-1:0]    o_value_out,
    output logic [COUNT_W-1:0]   o_active_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_take;
    t_result w_res;
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res_head;

    tih_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_func        (i_func),
        .i_transfer_id (i_transfer_id),
        .i_total_size  (i_total_size),
        .i_user_value  (i_user_value),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_take   (w_item_take)
    );

    tih_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_take  (w_item_take),
        .o_res        (w_res),
        .o_res_push   (w_res_push),
        .i_res_full   (w_res_full)
    );

    tih_fifo #(.WIDTH($bits(t_result))) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .i_data  (w_res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (w_res_head)
    );

    assign o_status       = w_res_head.status;
    assign o_descriptor   = w_res_head.desc;
    assign o_assigned_id  = w_res_head.assigned;
    assign o_size_out     = w_res_head.size;
    assign o_value_out    = w_res_head.value;
    assign o_active_count = w_res_head.count;

endmodule

### test/transfer_id_hash_table_tb.sv
`timescale 1ns / 1ps

module transfer_id_hash_table_tb;
    import tih_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_RSVD_LO = 3'd5;
    localparam logic [FUNC_W-1:0]    FUNC_RSVD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd2;
    localparam int STALL_LIMIT = 200000;
    localparam logic [WORD_W-1:0] ONES = '1;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [WORD_W-1:0]   id;
        logic [WORD_W-1:0]   size;
        logic [WORD_W-1:0]   value;
        bit                  fixed;
        logic [STATUS_W-1:0] fixed_status;
        logic [COUNT_W-1:0]  fixed_count;
    } t_op_item;

    typedef struct {
        t_result             res;
        bit                  fixed;
        logic [STATUS_W-1:0] fixed_status;
        logic [COUNT_W-1:0]  fixed_count;
    } t_answer;

    typedef struct {
        bit                   cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        t_op_item             op;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [FUNC_W-1:0]    i_func;
    logic [WORD_W-1:0]    i_transfer_id;
    logic [WORD_W-1:0]    i_total_size;
    logic [WORD_W-1:0]    i_user_value;
    logic                 empty;
    logic                 pop;
    logic [STATUS_W-1:0]  o_status;
    logic [DESC_W-1:0]    o_descriptor;
    logic [WORD_W-1:0]    o_assigned_id;
    logic [WORD_W-1:0]    o_size_out;
    logic [WORD_W-1:0]    o_value_out;
    logic [COUNT_W-1:0]   o_active_count;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0]    i_cfg_data;

    transfer_id_hash_table dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model
    logic [WORD_W-1:0] tbl_key   [CAPACITY];
    logic [WORD_W-1:0] tbl_size  [CAPACITY];
    logic [WORD_W-1:0] tbl_value [CAPACITY];
    int                tbl_link  [CAPACITY];
    logic [DESC_W-1:0] slot_desc [MAP_SLOTS];
    bit                slot_busy [MAP_SLOTS];
    int                free_idx;
    int                live_count;
    logic [WORD_W-1:0] gen_id;
    logic [WORD_W-1:0] cfg_initial;
    logic [WORD_W-1:0] cfg_stride;

    t_op_item send_q[$];
    t_answer  answer_q[$];
    t_row     dir_tbl[$];
    int  errors = 0;
    int  sent = 0;
    int  received = 0;
    int  status_seen[8];
    int  tx_idle = 0;
    int  rx_idle = 0;
    int  rx_hold_left = 0;
    int  quiet_cycles = 0;

    function automatic logic [SLOT_W-1:0] hash_home(logic [WORD_W-1:0] v);
        v ^= v >> MIX_SHIFT;
        v *= MIX_C1;
        v ^= v >> MIX_SHIFT;
        v *= MIX_C2;
        v ^= v >> MIX_SHIFT;
        return v[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] find_slot(logic [WORD_W-1:0] id, output bit hit,
                                                    output bit room);
        logic [SLOT_W-1:0] s;
        s = hash_home(id);
        hit = 0;
        room = 1;
        for (int n = 0; n < MAP_SLOTS; n++) begin
            if (!slot_busy[s]) return s;
            if (tbl_key[slot_desc[s]] == id) begin
                hit = 1;
                return s;
            end
            s++;
        end
        room = 0;
        return '0;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < MAP_SLOTS; i++) begin
            slot_busy[i] = 0;
            slot_desc[i] = '0;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_key[i] = '0;
            tbl_size[i] = '0;
            tbl_value[i] = '0;
            tbl_link[i] = i + 1;
        end
        free_idx = 0;
        live_count = 0;
    endfunction

    function automatic void release_slot(logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] hole, nxt, home;
        hole = slot;
        nxt = slot + 1'b1;
        for (int n = 0; n < MAP_SLOTS && slot_busy[nxt]; n++) begin
            home = hash_home(tbl_key[slot_desc[nxt]]);
            if (SLOT_W'(hole - home) < SLOT_W'(nxt - home)) begin
                slot_desc[hole] = slot_desc[nxt];
                hole = nxt;
            end
            nxt++;
        end
        slot_busy[hole] = 0;
        slot_desc[hole] = '0;
    endfunction

    function automatic logic [STATUS_W-1:0] store_entry(logic [WORD_W-1:0] id,
            logic [WORD_W-1:0] size, logic [WORD_W-1:0] value, output logic [DESC_W-1:0] d);
        bit hit, room;
        logic [SLOT_W-1:0] s;
        d = '0;
        if (id == 0) return STAT_ZERO_ID;
        if (free_idx >= CAPACITY) return STAT_FULL;
        s = find_slot(id, hit, room);
        if (hit) return STAT_DUPLICATE;
        if (!room) return STAT_FULL;
        d = DESC_W'(free_idx);
        free_idx = tbl_link[d];
        tbl_key[d] = id;
        tbl_size[d] = size;
        tbl_value[d] = value;
        tbl_link[d] = CAPACITY;
        slot_desc[s] = d;
        slot_busy[s] = 1;
        live_count++;
        return STAT_OK;
    endfunction

    function automatic t_result predict_op(t_op_item it);
        t_result r;
        bit hit, room;
        logic [SLOT_W-1:0] s;
        logic [WORD_W-1:0] cand;
        logic [DESC_W-1:0] d;
        r = '0;
        case (it.func)
            FUNC_INSERT: begin
                r.status = store_entry(it.id, it.size, it.value, d);
                r.desc = d;
                if (r.status == STAT_OK) r.assigned = it.id;
            end
            FUNC_ALLOC: begin
                if (free_idx >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    cand = gen_id;
                    hit = 1;
                    for (int i = 0; hit && i < CAPACITY; i++) begin
                        void'(find_slot(cand, hit, room));
                        if (hit) cand += cfg_stride;
                        if (cand == 0) cand += cfg_stride;
                    end
                    if (hit) begin
                        r.status = STAT_EXHAUSTED;
                    end else begin
                        r.status = store_entry(cand, it.size, it.value, d);
                        r.desc = d;
                        if (r.status == STAT_OK) begin
                            r.assigned = cand;
                            gen_id = cand + cfg_stride;
                            if (gen_id == 0) gen_id += cfg_stride;
                        end
                    end
                end
            end
            FUNC_LOOKUP, FUNC_REMOVE: begin
                hit = 0;
                s = '0;
                if (it.id != 0) s = find_slot(it.id, hit, room);
                if (!hit) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    d = slot_desc[s];
                    r.desc = d;
                    r.assigned = it.id;
                    if (it.func == FUNC_LOOKUP) begin
                        r.size = tbl_size[d];
                        r.value = tbl_value[d];
                    end else begin
                        release_slot(s);
                        tbl_key[d] = '0;
                        tbl_size[d] = '0;
                        tbl_value[d] = '0;
                        tbl_link[d] = free_idx;
                        free_idx = int'(d);
                        if (live_count > 0) live_count--;
                    end
                end
            end
            FUNC_CLEAR: clear_table();
            default: ;
        endcase
        if (r.status != STAT_OK) r.desc = '0;
        r.count = COUNT_W'(live_count);
        return r;
    endfunction

    task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        errors++;
        $display("%0t: mismatch on %s after %0d results: got %h, want %h",
                 $realtime, what, received, got, want);
    endtask

    // sender
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && push && !full) begin
            a.res = predict_op(send_q[0]);
            a.fixed = send_q[0].fixed;
            a.fixed_status = send_q[0].fixed_status;
            a.fixed_count = send_q[0].fixed_count;
            answer_q.push_back(a);
            void'(send_q.pop_front());
            sent++;
        end
        if (!(push && full)) begin
            if (i_rst_n && send_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                push <= 1'b1;
                i_func <= send_q[0].func;
                i_transfer_id <= send_q[0].id;
                i_total_size <= send_q[0].size;
                i_user_value <= send_q[0].value;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && pop && !empty) begin
            received++;
            status_seen[o_status]++;
            if (answer_q.size() == 0) begin
                report("unexpected transfer", WORD_W'(o_status), '0);
            end else begin
                a = answer_q.pop_front();
                if (o_status !== a.res.status)
                    report("status", WORD_W'(o_status), WORD_W'(a.res.status));
                if (o_descriptor !== a.res.desc)
                    report("descriptor", WORD_W'(o_descriptor), WORD_W'(a.res.desc));
                if (o_assigned_id !== a.res.assigned)
                    report("assigned_id", o_assigned_id, a.res.assigned);
                if (o_size_out !== a.res.size) report("size_out", o_size_out, a.res.size);
                if (o_value_out !== a.res.value) report("value_out", o_value_out, a.res.value);
                if (o_active_count !== a.res.count)
                    report("active_count", WORD_W'(o_active_count), WORD_W'(a.res.count));
                if (a.fixed && o_status !== a.fixed_status)
                    report("status (table)", WORD_W'(o_status), WORD_W'(a.fixed_status));
                if (a.fixed && o_active_count !== a.fixed_count)
                    report("active_count (table)", WORD_W'(o_active_count),
                           WORD_W'(a.fixed_count));
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n && ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_op(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] id,
                          logic [WORD_W-1:0] size, logic [WORD_W-1:0] value,
                          bit fixed = 0, logic [STATUS_W-1:0] st = '0,
                          logic [COUNT_W-1:0] cnt = '0);
        t_op_item it;
        @(negedge i_clk);
        while (send_q.size() >= 2) @(negedge i_clk);
        it.func = func;
        it.id = id;
        it.size = size;
        it.value = value;
        it.fixed = fixed;
        it.fixed_status = st;
        it.fixed_count = cnt;
        send_q.push_back(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (send_q.size() > 0 || push || answer_q.size() > 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] v;
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        v = (data == 0) ? 64'd1 : data;
        if (idx == CFG_INITIAL_ID) begin
            cfg_initial = v;
            gen_id = v;
        end else if (idx == CFG_ID_STRIDE) begin
            cfg_stride = v;
        end
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        return w >> $urandom_range(63);
    endfunction

    function automatic t_row op_row(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] id,
                                    logic [WORD_W-1:0] size, logic [WORD_W-1:0] value,
                                    bit fixed = 0, logic [STATUS_W-1:0] st = '0,
                                    int cnt = 0);
        t_row r;
        r.cfg = 0;
        r.cfg_idx = CFG_INITIAL_ID;
        r.op.func = func;
        r.op.id = id;
        r.op.size = size;
        r.op.value = value;
        r.op.fixed = fixed;
        r.op.fixed_status = st;
        r.op.fixed_count = COUNT_W'(cnt);
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        t_row r;
        r = op_row(FUNC_INSERT, data, '0, '0);
        r.cfg = 1;
        r.cfg_idx = idx;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_id(int live_pct);
        int r;
        int d;
        r = $urandom_range(99);
        if (r < live_pct && live_count > 0) begin
            d = $urandom_range(CAPACITY - 1);
            for (int i = 0; i < CAPACITY; i++) begin
                if (tbl_key[(d + i) % CAPACITY] != 0) return tbl_key[(d + i) % CAPACITY];
            end
        end
        if (r >= 97) return '0;
        if (r >= 85) return WORD_W'($urandom_range(1, 300));
        return rand_word();
    endfunction

    task automatic random_ops(int n);
        int r;
        logic [FUNC_W-1:0] f;
        for (int i = 0; i < n; i++) begin
            @(negedge i_clk);
            while (send_q.size() >= 2) @(negedge i_clk);
            r = $urandom_range(99);
            if (r < 30) f = FUNC_INSERT;
            else if (r < 45) f = FUNC_ALLOC;
            else if (r < 70) f = FUNC_LOOKUP;
            else if (r < 95) f = FUNC_REMOVE;
            else if (r < 97) f = FUNC_CLEAR;
            else f = FUNC_CLEAR + FUNC_W'($urandom_range(1, 3));
            add_op(f, pick_id(f == FUNC_INSERT ? 15 : 70), rand_word(), rand_word());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        pop <= 1'b0;
        i_func <= FUNC_INSERT;
        i_transfer_id <= '0;
        i_total_size <= '0;
        i_user_value <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_INITIAL_ID;
        i_cfg_data <= '0;
        clear_table();
        cfg_initial = 1;
        cfg_stride = 1;
        gen_id = 1;

        // directed table
        dir_tbl.push_back(op_row(FUNC_LOOKUP, 64'd5, '0, '0, 1, STAT_NOT_FOUND, 0));
        dir_tbl.push_back(op_row(FUNC_INSERT, '0, ONES, ONES, 1, STAT_ZERO_ID, 0));
        dir_tbl.push_back(op_row(FUNC_REMOVE, '0, '0, '0, 1, STAT_NOT_FOUND, 0));
        dir_tbl.push_back(op_row(FUNC_INSERT, ONES, ONES, ONES, 1, STAT_OK, 1));
        dir_tbl.push_back(op_row(FUNC_INSERT, ONES, '0, '0, 1, STAT_DUPLICATE, 1));
        dir_tbl.push_back(op_row(FUNC_LOOKUP, ONES, '0, '0));
        dir_tbl.push_back(op_row(FUNC_ALLOC, '0, 64'h1234, 64'h5678, 1, STAT_OK, 2));
        dir_tbl.push_back(op_row(FUNC_INSERT, 64'd2, '0, ONES, 1, STAT_OK, 3));
        dir_tbl.push_back(op_row(FUNC_ALLOC, ONES, ONES, '0));
        dir_tbl.push_back(op_row(FUNC_RSVD_LO, ONES, ONES, ONES, 1, STAT_OK, 4));
        dir_tbl.push_back(op_row(FUNC_RSVD_HI, 64'd2, '0, '0, 1, STAT_OK, 4));
        dir_tbl.push_back(op_row(FUNC_LOOKUP, 64'd3, '0, '0));
        dir_tbl.push_back(op_row(FUNC_REMOVE, ONES, '0, '0, 1, STAT_OK, 3));
        dir_tbl.push_back(op_row(FUNC_LOOKUP, ONES, '0, '0, 1, STAT_NOT_FOUND, 3));
        dir_tbl.push_back(op_row(FUNC_CLEAR, '0, '0, '0, 1, STAT_OK, 0));
        for (int i = 0; i < CAPACITY; i++)
            dir_tbl.push_back(op_row(FUNC_INSERT, {32'hA5A50000 + 32'(i), $urandom},
                                     rand_word(), rand_word()));
        dir_tbl.push_back(op_row(FUNC_INSERT, 64'd77, '0, '0, 1, STAT_FULL, CAPACITY));
        dir_tbl.push_back(op_row(FUNC_ALLOC, '0, '0, '0, 1, STAT_FULL, CAPACITY));
        dir_tbl.push_back(op_row(FUNC_CLEAR, '0, '0, '0, 1, STAT_OK, 0));
        dir_tbl.push_back(cfg_row(CFG_INITIAL_ID, 64'd5));
        dir_tbl.push_back(cfg_row(CFG_ID_STRIDE, 64'h8000000000000000));
        dir_tbl.push_back(op_row(FUNC_INSERT, 64'd5, '0, '0, 1, STAT_OK, 1));
        dir_tbl.push_back(op_row(FUNC_INSERT, 64'h8000000000000005, '0, '0, 1, STAT_OK, 2));
        dir_tbl.push_back(op_row(FUNC_ALLOC, '0, '0, '0, 1, STAT_EXHAUSTED, 2));
        dir_tbl.push_back(cfg_row(CFG_ID_STRIDE, '0));
        dir_tbl.push_back(cfg_row(CFG_UNUSED, 64'd99));
        dir_tbl.push_back(op_row(FUNC_ALLOC, '0, '0, '0));
        dir_tbl.push_back(cfg_row(CFG_INITIAL_ID, ONES));
        dir_tbl.push_back(op_row(FUNC_ALLOC, '0, '0, '0));
        dir_tbl.push_back(op_row(FUNC_ALLOC, '0, '0, '0));
        dir_tbl.push_back(cfg_row(CFG_INITIAL_ID, '0));
        dir_tbl.push_back(op_row(FUNC_CLEAR, '0, '0, '0, 1, STAT_OK, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].cfg) begin
                write_reg(dir_tbl[k].cfg_idx, dir_tbl[k].op.id);
            end else begin
                add_op(dir_tbl[k].op.func, dir_tbl[k].op.id, dir_tbl[k].op.size,
                       dir_tbl[k].op.value, dir_tbl[k].op.fixed, dir_tbl[k].op.fixed_status,
                       dir_tbl[k].op.fixed_count);
            end
        end

        // random traffic
        write_reg(CFG_INITIAL_ID, 64'd1);
        write_reg(CFG_ID_STRIDE, 64'd1);
        tx_idle = 25;
        rx_idle = 54;
        random_ops(560);
        write_reg(CFG_INITIAL_ID, 64'hFFFFFFFFFFFFFFF0);
        write_reg(CFG_ID_STRIDE, 64'd3);
        tx_idle = 54;
        rx_idle = 25;
        random_ops(560);
        write_reg(CFG_INITIAL_ID, rand_word());
        write_reg(CFG_ID_STRIDE, ONES);
        tx_idle = 0;
        rx_idle = 0;
        @(negedge i_clk);
        rx_hold_left = 1500;
        random_ops(560);
        drain();

        $display("%0d operations sent, %0d results checked, %0d mismatches", sent, received,
                 errors);
        $display("status mix ok/zero/full/dup/missing/exhausted: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
